/* design/sphere_triangle_overlap_test_top_defines.svh */
// Assertion macros for the sphere/triangle overlap test.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef SPHERE_TRIANGLE_OVERLAP_TEST_TOP_DEFINES_SVH
`define SPHERE_TRIANGLE_OVERLAP_TEST_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define STOT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define STOT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/stot_pkg.sv */
// Package for the sphere/triangle overlap test: default widths and
// configuration register indices. No dependencies.
`timescale 1ns / 1ps

package stot_pkg;

    localparam int STOT_COORD_WIDTH      = 16;
    localparam int STOT_NORMAL_FRAC_BITS = 14;

    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } cfg_reg_t;

endpackage

/* design/sphere_triangle_overlap_test_top.sv */
// Sphere/triangle overlap test, five stages, one triangle per unstalled clock.
// Depends on stot_pkg; port checker bound in from stot_checker.sv.
`timescale 1ns / 1ps

// The sphere (centre, radius) sits in four configuration registers; each
// triangle word (three vertices in signed Q7.8 plus a unit normal in signed
// Q1.14) yields one hit word. A hit needs |n.(c - v1)| <= r * 2^14 and each of
// the edge-plane values (n x edge).(c - edge start), one per edge, to be non-negative.
// Contact made only by an edge or a corner with the centre outside the
// triangle's prism is not reported. An accepted triangle word reaches its hit
// word through the multiply chain: differences, normal-by-edge products, cross
// product and plane compare, edge-plane products, final sums. A new triangle
// may be taken on every clock with tri_stall low. Each stage carries its own
// valid bit and holds only while the stage after it is full and held, so
// empty slots close up and the pipeline keeps taking words while a finished
// hit waits in the output register. tri_stall rises only when every stage is
// full and res_stall is high. Registers must be written only while the
// pipeline is empty; the block does not enforce this. The centre is sampled in
// stage one, the radius in stage three. There is no clearing pass after reset.
module sphere_triangle_overlap_test_top #(
    parameter int COORD_WIDTH      = stot_pkg::STOT_COORD_WIDTH,
    parameter int NORMAL_FRAC_BITS = stot_pkg::STOT_NORMAL_FRAC_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // configuration
    input  logic                                    cfg_we,
    input  logic [stot_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [COORD_WIDTH-1:0]                  cfg_data,
    // triangle words
    input  logic                                    tri_valid,
    output logic                                    tri_stall,
    input  logic signed [COORD_WIDTH-1:0]           v1_x,
    input  logic signed [COORD_WIDTH-1:0]           v1_y,
    input  logic signed [COORD_WIDTH-1:0]           v1_z,
    input  logic signed [COORD_WIDTH-1:0]           v2_x,
    input  logic signed [COORD_WIDTH-1:0]           v2_y,
    input  logic signed [COORD_WIDTH-1:0]           v2_z,
    input  logic signed [COORD_WIDTH-1:0]           v3_x,
    input  logic signed [COORD_WIDTH-1:0]           v3_y,
    input  logic signed [COORD_WIDTH-1:0]           v3_z,
    input  logic signed [NORMAL_FRAC_BITS+1:0]      nrm_x,
    input  logic signed [NORMAL_FRAC_BITS+1:0]      nrm_y,
    input  logic signed [NORMAL_FRAC_BITS+1:0]      nrm_z,
    // hit words
    output logic                                    res_valid,
    input  logic                                    res_stall,
    output logic                                    hit
);
    import stot_pkg::*;

    // widths
    localparam int NW   = NORMAL_FRAC_BITS + 2;   // normal
    localparam int RW   = COORD_WIDTH - 1;        // radius
    localparam int DW   = COORD_WIDTH + 1;        // coordinate difference
    localparam int PW   = NW + DW;                // normal * difference
    localparam int CPW  = PW + 1;                 // cross product component
    localparam int CMPW = PW + 3;                 // plane distance vs radius
    localparam int EPW  = CPW + DW;               // edge-plane product
    localparam int DOTW = EPW + 2;                // edge-plane sum

    // ---------------- configuration registers ----------------
    logic signed [COORD_WIDTH-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic        [RW-1:0]          radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_CENTER_Z: center_z_reg <= cfg_data;
                REG_RADIUS:   radius_reg   <= cfg_data[RW-1:0];
                default:      ;
            endcase
        end
    end

    // ---------------- stage valid bits and hold chain ----------------
    logic va_reg, vb_reg, vc_reg, vd_reg, ve_reg;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

    // a stage may load when it is empty or its word moves on this clock
    assign rdy_e = !ve_reg || !res_stall;
    assign rdy_d = !vd_reg || rdy_e;
    assign rdy_c = !vc_reg || rdy_d;
    assign rdy_b = !vb_reg || rdy_c;
    assign rdy_a = !va_reg || rdy_b;

    assign tri_stall = !rdy_a;
    assign res_valid = ve_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a) va_reg <= tri_valid;
            if (rdy_b) vb_reg <= va_reg;
            if (rdy_c) vc_reg <= vb_reg;
            if (rdy_d) vd_reg <= vc_reg;
            if (rdy_e) ve_reg <= vd_reg;
        end
    end

    // ---------------- stage A: differences ----------------
    // edge k runs from vertex k against the vertex before it:
    //   e0 = v1 - v3, e1 = v2 - v1, e2 = v3 - v2
    // dc[k] = c - start vertex of edge k; dc[0] also feeds the plane distance
    logic signed [NW-1:0] n_a_next [3];
    logic signed [DW-1:0] e_a_next [3][3];
    logic signed [DW-1:0] dc_a_next [3][3];
    logic signed [NW-1:0] n_a_reg [3];
    logic signed [DW-1:0] e_a_reg [3][3];
    logic signed [DW-1:0] dc_a_reg [3][3];

    always_comb
    begin
        logic signed [COORD_WIDTH-1:0] v [3][3];
        logic signed [COORD_WIDTH-1:0] c [3];
        v[0][0] = v1_x; v[0][1] = v1_y; v[0][2] = v1_z;
        v[1][0] = v2_x; v[1][1] = v2_y; v[1][2] = v2_z;
        v[2][0] = v3_x; v[2][1] = v3_y; v[2][2] = v3_z;
        c[0] = center_x_reg; c[1] = center_y_reg; c[2] = center_z_reg;
        n_a_next[0] = nrm_x;
        n_a_next[1] = nrm_y;
        n_a_next[2] = nrm_z;
        for (int j = 0; j < 3; j++)
        begin
            e_a_next[0][j]  = DW'(v[0][j]) - DW'(v[2][j]);
            e_a_next[1][j]  = DW'(v[1][j]) - DW'(v[0][j]);
            e_a_next[2][j]  = DW'(v[2][j]) - DW'(v[1][j]);
            for (int k = 0; k < 3; k++)
            begin
                dc_a_next[k][j] = DW'(c[j]) - DW'(v[k][j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && tri_valid)
        begin
            n_a_reg  <= n_a_next;
            e_a_reg  <= e_a_next;
            dc_a_reg <= dc_a_next;
        end
    end

    // ---------------- stage B: normal x edge products, plane products ------
    // per edge, products in pairs for the cross product:
    //   [0]=n1*e2 [1]=n2*e1 [2]=n2*e0 [3]=n0*e2 [4]=n0*e1 [5]=n1*e0
    logic signed [PW-1:0] mp_b_next [3][6];
    logic signed [PW-1:0] pp_b_next [3];
    logic signed [PW-1:0] mp_b_reg [3][6];
    logic signed [PW-1:0] pp_b_reg [3];
    logic signed [DW-1:0] dc_b_reg [3][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mp_b_next[k][0] = PW'(n_a_reg[1]) * PW'(e_a_reg[k][2]);
            mp_b_next[k][1] = PW'(n_a_reg[2]) * PW'(e_a_reg[k][1]);
            mp_b_next[k][2] = PW'(n_a_reg[2]) * PW'(e_a_reg[k][0]);
            mp_b_next[k][3] = PW'(n_a_reg[0]) * PW'(e_a_reg[k][2]);
            mp_b_next[k][4] = PW'(n_a_reg[0]) * PW'(e_a_reg[k][1]);
            mp_b_next[k][5] = PW'(n_a_reg[1]) * PW'(e_a_reg[k][0]);
        end
        for (int j = 0; j < 3; j++)
        begin
            pp_b_next[j] = PW'(n_a_reg[j]) * PW'(dc_a_reg[0][j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_b && va_reg)
        begin
            mp_b_reg <= mp_b_next;
            pp_b_reg <= pp_b_next;
            dc_b_reg <= dc_a_reg;
        end
    end

    // ---------------- stage C: cross products, plane distance check --------
    logic signed [CPW-1:0] cr_c_next [3][3];
    logic                  near_c_next;
    logic signed [CPW-1:0] cr_c_reg [3][3];
    logic                  near_c_reg;
    logic signed [DW-1:0]  dc_c_reg [3][3];

    always_comb
    begin
        logic signed [CMPW-1:0] plane_d;
        logic signed [CMPW-1:0] rad;
        logic signed [CMPW-1:0] d_minus_r;
        logic signed [CMPW-1:0] d_plus_r;
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cr_c_next[k][i] = CPW'(mp_b_reg[k][2*i]) - CPW'(mp_b_reg[k][2*i+1]);
            end
        end
        plane_d   = CMPW'(pp_b_reg[0]) + CMPW'(pp_b_reg[1]) + CMPW'(pp_b_reg[2]);
        rad       = $signed(CMPW'(radius_reg) << NORMAL_FRAC_BITS);
        d_minus_r = plane_d - rad;
        d_plus_r  = plane_d + rad;
        // |plane_d| <= rad, touching counts
        near_c_next = !((!d_minus_r[CMPW-1] && (d_minus_r != '0)) || d_plus_r[CMPW-1]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy_c && vb_reg)
        begin
            cr_c_reg   <= cr_c_next;
            near_c_reg <= near_c_next;
            dc_c_reg   <= dc_b_reg;
        end
    end

    // ---------------- stage D: edge-plane products ----------------
    logic signed [EPW-1:0] ep_d_next [3][3];
    logic signed [EPW-1:0] ep_d_reg [3][3];
    logic                  near_d_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ep_d_next[k][i] = EPW'(cr_c_reg[k][i]) * EPW'(dc_c_reg[k][i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_d && vc_reg)
        begin
            ep_d_reg   <= ep_d_next;
            near_d_reg <= near_c_reg;
        end
    end

    // ---------------- stage E: sums, sign tests, output register ----------
    logic hit_next;
    logic hit_reg;

    always_comb
    begin
        logic signed [DOTW-1:0] s;
        hit_next = near_d_reg;
        for (int k = 0; k < 3; k++)
        begin
            s = DOTW'(ep_d_reg[k][0]) + DOTW'(ep_d_reg[k][1]) + DOTW'(ep_d_reg[k][2]);
            if (s[DOTW-1])
            begin
                hit_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_e && vd_reg)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

/* design/stot_checker.sv */
// Port checker for the sphere/triangle overlap test, bound to the top level.
// Depends on sphere_triangle_overlap_test_top_defines.svh.
`timescale 1ns / 1ps
`include "sphere_triangle_overlap_test_top_defines.svh"

module stot_checker (
    input logic clk,
    input logic rst_n,
    input logic tri_stall,
    input logic res_valid,
    input logic res_stall,
    input logic hit
);

    // a held hit word stays
    `STOT_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(hit), "hit word changed while held")

    // input is held off only when the output is full and held
    `STOT_ASSERT_NOW(a_stall_src, tri_stall, res_valid && res_stall, "triangle stalled with output free")

    // nothing comes out on the first clock after reset
    `STOT_ASSERT_NOW(a_reset_empty, !$past(rst_n), !res_valid, "hit word straight out of reset")

    // an empty output register frees the input side at once
    `STOT_ASSERT_NOW(a_no_block, !res_valid, !tri_stall, "stall with empty output")

endmodule

bind sphere_triangle_overlap_test_top stot_checker u_stot_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tri_stall (tri_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .hit       (hit)
);

/* verif/sphere_triangle_overlap_test_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for sphere_triangle_overlap_test_top: streams triangle words,
// predicts each hit word bit for bit and checks it, with random idling on both channels.
// Depends on stot_pkg and the block's RTL only.

module sphere_triangle_overlap_test_top_tb;
    import stot_pkg::*;

    localparam int CW          = STOT_COORD_WIDTH;
    localparam int NFB         = STOT_NORMAL_FRAC_BITS;
    localparam int NW          = NFB + 2;
    localparam int RW          = CW - 1;
    localparam int UNIT_N      = 1 << NFB;            // 1.0 in the normal's format
    localparam longint COORD_MAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint COORD_MIN = -(64'sd1 <<< (CW - 1));
    localparam int CLK_PERIOD  = 10;
    localparam int PIPE_SETTLE = 12;                  // five-stage pipe, plus margin
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [NW-1:0] normal_t;

    // Packed so that the whole triangle maps onto the port concatenation below:
    // vtx[vertex][axis], axis 0 = x.
    typedef struct packed {
        normal_t [2:0]      nrm;
        coord_t  [2:0][2:0] vtx;
    } triangle_t;

    typedef longint vec3_t [3];

    // ------------------------------------------------------------------
    // Block ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_CENTER_X;
    logic [CW-1:0]              cfg_data  = '0;
    logic                       tri_valid = 1'b0;
    logic                       tri_stall;
    coord_t                     v1_x = '0, v1_y = '0, v1_z = '0;
    coord_t                     v2_x = '0, v2_y = '0, v2_z = '0;
    coord_t                     v3_x = '0, v3_y = '0, v3_z = '0;
    normal_t                    nrm_x = '0, nrm_y = '0, nrm_z = '0;
    logic                       res_valid;
    logic                       res_stall = 1'b0;
    logic                       hit;

    // Our own copy of the sphere registers, updated as each write lands
    coord_t                     sphere_centre [3] = '{default: '0};
    logic [RW-1:0]              sphere_radius = '0;

    bit                         pending_hits [$];     // expected hit words, oldest first
    int unsigned                hit_errors  = 0;
    int unsigned                cycle_count = 0;
    bit                         src_calm    = 1'b0;   // no gaps from the sender
    bit                         sink_calm   = 1'b0;   // no stalls from the receiver

    sphere_triangle_overlap_test_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tri_valid (tri_valid),
        .tri_stall (tri_stall),
        .v1_x      (v1_x),
        .v1_y      (v1_y),
        .v1_z      (v1_z),
        .v2_x      (v2_x),
        .v2_y      (v2_y),
        .v2_z      (v2_z),
        .v3_x      (v3_x),
        .v3_y      (v3_y),
        .v3_z      (v3_z),
        .nrm_x     (nrm_x),
        .nrm_y     (nrm_y),
        .nrm_z     (nrm_z),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .hit       (hit)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Hit predictor. Everything is exact in 64 bits: the largest term is a
    // cross-product component (~2^32) times a centre offset (~2^16).
    // ------------------------------------------------------------------
    function automatic longint vtx_at(triangle_t t, int v, int a);
        return longint'(signed'(t.vtx[v][a]));
    endfunction

    // Edge plane through a, spanned by the normal and the edge a - b; the
    // centre must not lie strictly on its negative side.
    function automatic bit edge_plane_ok(vec3_t n, vec3_t a, vec3_t b, vec3_t c);
        vec3_t e;
        vec3_t p;
        int    i;
        for (i = 0; i < 3; i++)
            e[i] = a[i] - b[i];
        p[0] = n[1] * e[2] - n[2] * e[1];
        p[1] = n[2] * e[0] - n[0] * e[2];
        p[2] = n[0] * e[1] - n[1] * e[0];
        return (p[0] * (c[0] - a[0]) + p[1] * (c[1] - a[1]) + p[2] * (c[2] - a[2])) >= 0;
    endfunction

    function automatic bit predict_hit(triangle_t t);
        vec3_t  v1, v2, v3, n, c;
        longint plane_d;
        longint reach;
        int     a;
        for (a = 0; a < 3; a++)
        begin
            v1[a] = vtx_at(t, 0, a);
            v2[a] = vtx_at(t, 1, a);
            v3[a] = vtx_at(t, 2, a);
            n[a]  = longint'(signed'(t.nrm[a]));
            c[a]  = longint'(sphere_centre[a]);
        end
        // plane distance carries the normal's fraction, so the radius is
        // brought up to match; touching at exactly the radius is a hit
        plane_d = n[0] * (c[0] - v1[0]) + n[1] * (c[1] - v1[1]) + n[2] * (c[2] - v1[2]);
        reach   = longint'(sphere_radius) <<< NFB;
        if (plane_d > reach || plane_d < -reach)
            return 1'b0;
        return edge_plane_ok(n, v1, v3, c) && edge_plane_ok(n, v2, v1, c)
            && edge_plane_ok(n, v3, v2, c);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic coord_t clamp_coord(longint x);
        if (x > COORD_MAX)
            return coord_t'(COORD_MAX);
        if (x < COORD_MIN)
            return coord_t'(COORD_MIN);
        return coord_t'(x);
    endfunction

    function automatic triangle_t flat_tri(longint ax, longint ay, longint az,
                                           longint bx, longint by, longint bz,
                                           longint cx, longint cy, longint cz,
                                           longint nx, longint ny, longint nz);
        triangle_t t;
        t.vtx[0][0] = coord_t'(ax);
        t.vtx[0][1] = coord_t'(ay);
        t.vtx[0][2] = coord_t'(az);
        t.vtx[1][0] = coord_t'(bx);
        t.vtx[1][1] = coord_t'(by);
        t.vtx[1][2] = coord_t'(bz);
        t.vtx[2][0] = coord_t'(cx);
        t.vtx[2][1] = coord_t'(cy);
        t.vtx[2][2] = coord_t'(cz);
        t.nrm[0]    = normal_t'(nx);
        t.nrm[1]    = normal_t'(ny);
        t.nrm[2]    = normal_t'(nz);
        return t;
    endfunction

    function automatic triangle_t noise_triangle();
        triangle_t t;
        int        v, a;
        for (v = 0; v < 3; v++)
            for (a = 0; a < 3; a++)
                t.vtx[v][a] = coord_t'($urandom);
        for (a = 0; a < 3; a++)
            t.nrm[a] = normal_t'($urandom);
        return t;
    endfunction

    // Vertices scattered around the current centre, with the right-handed
    // unit normal (v2 - v1) x (v3 - v1) quantised to the normal's format.
    // This keeps plane distances near the radius and the centre often
    // inside the prism, so hits and both kinds of miss all turn up.
    function automatic triangle_t shaped_triangle(int unsigned spread);
        triangle_t t;
        real       e1 [3];
        real       e2 [3];
        real       nr [3];
        real       len, q;
        int        v, a, axis;
        for (v = 0; v < 3; v++)
            for (a = 0; a < 3; a++)
                t.vtx[v][a] = clamp_coord(longint'(sphere_centre[a])
                    + longint'($urandom_range(0, 2 * spread)) - longint'(spread));
        for (a = 0; a < 3; a++)
        begin
            e1[a] = real'(vtx_at(t, 1, a) - vtx_at(t, 0, a));
            e2[a] = real'(vtx_at(t, 2, a) - vtx_at(t, 0, a));
        end
        nr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        nr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        nr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        len   = $sqrt(nr[0] * nr[0] + nr[1] * nr[1] + nr[2] * nr[2]);
        if (len < 1.0)
        begin
            // collapsed triangle: any axis will do
            axis      = $urandom_range(0, 2);
            t.nrm     = '0;
            t.nrm[axis] = ($urandom_range(0, 1) != 0) ? normal_t'(UNIT_N) : normal_t'(-UNIT_N);
        end
        else
            for (a = 0; a < 3; a++)
            begin
                q        = nr[a] * UNIT_N / len;
                t.nrm[a] = normal_t'($rtoi(q < 0.0 ? q - 0.5 : q + 0.5));
            end
        // now and then the wrong winding, which should fail the edge planes
        if ($urandom_range(0, 9) == 0)
            for (a = 0; a < 3; a++)
                t.nrm[a] = -t.nrm[a];
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Channel tasks. Inputs change only by NBA at a rising edge, and each
    // signal gets at most one NBA per edge.
    // ------------------------------------------------------------------
    task automatic send_triangle(input triangle_t t);
        int unsigned gap;
        gap = src_calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            tri_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tri_valid <= 1'b1;
        {nrm_z, nrm_y, nrm_x, v3_z, v3_y, v3_x, v2_z, v2_y, v2_x, v1_z, v1_y, v1_x} <= t;
        @(posedge clk);
        while (tri_stall)
            @(posedge clk);
    endtask

    // Stop sending and let every expected hit word come back, then give the
    // pipe time to empty completely.
    task automatic wait_for_idle();
        tri_valid <= 1'b0;
        @(posedge clk);
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t which, input logic [CW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge clk);
        case (which)
            REG_CENTER_X: sphere_centre[0] = coord_t'(value);
            REG_CENTER_Y: sphere_centre[1] = coord_t'(value);
            REG_CENTER_Z: sphere_centre[2] = coord_t'(value);
            REG_RADIUS:   sphere_radius    = value[RW-1:0];   // top bit not stored
            default: ;
        endcase
    endtask

    // Only ever called with the pipe empty
    task automatic load_sphere(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                               input logic [CW-1:0] cz, input logic [CW-1:0] rad);
        wait_for_idle();
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS, rad);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers still at reset: point sphere at the origin
    task automatic test_reset_values();
        // zero normal: every distance and edge value is zero, so a hit
        send_triangle(flat_tri(3000, -700, 12, -5, 900, 44, 1, 2, 3, 0, 0, 0));
        // origin inside a flat triangle, distance exactly zero
        send_triangle(flat_tri(-512, -512, 0, 512, -512, 0, 0, 512, 0, 0, 0, UNIT_N));
        // same triangle one LSB up
        send_triangle(flat_tri(-512, -512, 1, 512, -512, 1, 0, 512, 1, 0, 0, UNIT_N));
    endtask

    // Extreme register and field values, including the -2.0 normal
    task automatic test_field_extremes();
        // radius written with its unused top bit set
        load_sphere(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_triangle(flat_tri(32767, 32767, 32767, 32767, 32767, 32767,
                               32767, 32767, 32767, 0, 0, UNIT_N));
        send_triangle(flat_tri(-32768, -32768, -32768, 32767, -32768, 32767,
                               -32768, 32767, 32767, -32768, -32768, -32768));
        send_triangle(flat_tri(32767, -32768, 32767, -32768, 32767, -32768,
                               32767, 32767, -32768, 32767, 32767, 32767));
        send_triangle(flat_tri(32767, -32768, 32000, 32767, -32768, -32768,
                               -32768, -32768, 32767, -UNIT_N, UNIT_N, -UNIT_N));
        send_triangle(flat_tri(0, 0, 0, 32767, 0, 0, 0, -32768, 0, 0, -32768, 0));
        load_sphere(16'h8000, 16'h7FFF, 16'h8000, 16'h0000);
        send_triangle(flat_tri(-32768, 32767, -32768, -32768, 32767, -32768,
                               -32768, 32767, -32768, UNIT_N, UNIT_N, UNIT_N));
        send_triangle(flat_tri(-32768, -32768, -32768, 32767, 32767, -32768,
                               -32768, 32767, 32767, -32768, 32767, -32768));
        send_triangle(flat_tri(-32768, 32767, -32767, 32767, 32767, -32767,
                               -32768, -32768, -32767, 0, 0, -UNIT_N));
    endtask

    // Plane distance right at the radius, on both sides, and winding versus
    // normal sign. Centre (0, 0, 4.0), radius 1.0.
    task automatic test_plane_distance();
        load_sphere(16'h0000, 16'h0000, 16'h0400, 16'h0100);
        send_triangle(flat_tri(-512, -512, 'h300, 512, -512, 'h300, 0, 512, 'h300,
                               0, 0, UNIT_N));   // just touching from below
        send_triangle(flat_tri(-512, -512, 'h2FF, 512, -512, 'h2FF, 0, 512, 'h2FF,
                               0, 0, UNIT_N));   // one LSB too far
        send_triangle(flat_tri(-512, -512, 'h500, 512, -512, 'h500, 0, 512, 'h500,
                               0, 0, UNIT_N));   // just touching from above
        send_triangle(flat_tri(-512, -512, 'h501, 512, -512, 'h501, 0, 512, 'h501,
                               0, 0, UNIT_N));
        // downward normal: clockwise order passes the edges, counter-clockwise fails
        send_triangle(flat_tri(-512, -512, 'h300, 0, 512, 'h300, 512, -512, 'h300,
                               0, 0, -UNIT_N));
        send_triangle(flat_tri(-512, -512, 'h300, 512, -512, 'h300, 0, 512, 'h300,
                               0, 0, -UNIT_N));
    endtask

    // Collapsed triangles, and contact the block is not meant to see
    task automatic test_degenerate_and_contact();
        // all vertices on one point in the centre's plane: every edge is zero
        send_triangle(flat_tri('h1000, 'h1000, 'h400, 'h1000, 'h1000, 'h400,
                               'h1000, 'h1000, 'h400, 0, 0, UNIT_N));
        // two vertices shared
        send_triangle(flat_tri(-256, -256, 'h400, -256, -256, 'h400, 256, 256, 'h400,
                               UNIT_N, 0, 0));
        // centre 1/16 outside an edge, sphere plainly touching: still a miss
        send_triangle(flat_tri('h10, -512, 'h400, 'h400, -512, 'h400, 'h10, 512, 'h400,
                               0, 0, UNIT_N));
        // corner poking into the sphere, centre outside the prism
        send_triangle(flat_tri('h40, 'h40, 'h400, 'h800, 'h40, 'h400, 'h40, 'h800, 'h400,
                               0, 0, UNIT_N));
        // normal of magnitude 2: distance doubles and lands exactly on the radius
        send_triangle(flat_tri(-512, -512, 'h380, 512, -512, 'h380, 0, 512, 'h380,
                               0, 0, -32768));
    endtask

    // Random spheres, each followed by a stream of triangles. Most triangles
    // are built around the centre; the rest are collapsed, carry a non-unit
    // normal, or are pure noise.
    task automatic test_random_spheres(input int unsigned phases,
                                       input int unsigned words_per_phase);
        int unsigned   ph, k, kind, lo, hi, spread;
        logic [CW-1:0] cx, cy, cz, rad;
        triangle_t     t;
        for (ph = 0; ph < phases; ph++)
        begin
            cx  = CW'($urandom_range(0, 16000) - 8000);
            cy  = CW'($urandom_range(0, 16000) - 8000);
            cz  = CW'($urandom_range(0, 16000) - 8000);
            rad = CW'($urandom_range(0, 4000));
            case (ph % 6)
                0: rad = 16'h0200;
                1: rad = 16'h0000;
                2: rad = 16'h7FFF;
                3:
                begin
                    // anywhere at all; many vertices end up clamped
                    cx  = CW'($urandom);
                    cy  = CW'($urandom);
                    cz  = CW'($urandom);
                    rad = CW'($urandom);
                end
                default: ;
            endcase
            load_sphere(cx, cy, cz, rad);
            // one phase with no idling at all, one where only the receiver
            // stalls (so the pipe fills), one where only the sender idles
            src_calm  = (ph % 6 == 0) || (ph % 6 == 4);
            sink_calm = (ph % 6 == 0) || (ph % 6 == 5);
            lo = (sphere_radius / 2 + 8 < 6000) ? sphere_radius / 2 + 8 : 6000;
            hi = (sphere_radius * 2 + 64 < 12000) ? sphere_radius * 2 + 64 : 12000;
            for (k = 0; k < words_per_phase; k++)
            begin
                kind   = $urandom_range(0, 99);
                spread = $urandom_range(lo, hi);
                t      = shaped_triangle(spread);
                if (kind >= 72 && kind < 82)
                begin
                    t.vtx[1] = t.vtx[0];
                    if (kind >= 78)
                        t.vtx[2] = t.vtx[0];
                end
                else if (kind >= 82 && kind < 90)
                begin
                    t.nrm[0] = normal_t'($urandom);
                    t.nrm[1] = normal_t'($urandom);
                    t.nrm[2] = normal_t'($urandom);
                end
                else if (kind >= 90)
                    t = noise_triangle();
                send_triangle(t);
            end
        end
        src_calm  = 1'b0;
        sink_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver pacing: alternating stall and free runs, stall runs mostly
    // short with the odd long one.
    // ------------------------------------------------------------------
    initial
    begin : sink_pacing
        bit          holding;
        int unsigned run;
        holding = 1'b0;
        run     = 0;
        forever
        begin
            @(posedge clk);
            if (run != 0)
                run--;
            else
            begin
                holding = !holding && !sink_calm;
                run     = holding ? pick_gap() : $urandom_range(0, 16);
            end
            res_stall <= holding;
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: on each edge, predict for a triangle word taken, then
    // check a hit word taken. Inputs are sampled before this edge's NBAs.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : hit_scoreboard
        triangle_t seen;
        bit        want;
        if (rst_n && tri_valid && !tri_stall)
        begin
            seen = {nrm_z, nrm_y, nrm_x, v3_z, v3_y, v3_x, v2_z, v2_y, v2_x,
                    v1_z, v1_y, v1_x};
            pending_hits.push_back(predict_hit(seen));
        end
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_hits.size() == 0)
            begin
                hit_errors++;
                $display("%0t: hit word with none expected, got %b", $time, hit);
            end
            else
            begin
                want = pending_hits.pop_front();
                if (hit !== want)
                begin
                    hit_errors++;
                    $display("%0t: hit mismatch, expected %b, got %b", $time, want, hit);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : regression
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_field_extremes();
        test_plane_distance();
        test_degenerate_and_contact();
        test_random_spheres(6, 255);

        wait_for_idle();
        if (hit_errors == 0 && pending_hits.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sphere_triangle_overlap_test_top.f */
+incdir+design
design/stot_pkg.sv
design/sphere_triangle_overlap_test_top.sv
design/stot_checker.sv
verif/sphere_triangle_overlap_test_top_tb.sv
